// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers used by pending_ack_retry_table_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: property failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/prtt_pkg.sv =====
// ----------------------------------------------------------------------------
// prtt_pkg
// types and constants of the pending ack retry table
// ----------------------------------------------------------------------------
package prtt_pkg;

   localparam int unsigned NUM_SLOTS = 10;
   localparam int unsigned SLOT_W    = 4;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned MAC_W     = 48;
   localparam int unsigned ACK_W     = 8;
   localparam int unsigned MSG_W     = 16;
   localparam int unsigned RETRY_W   = 4;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(5);

   typedef enum logic [CMD_W-1:0] {
      CMD_STORE  = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CHECK  = 2'd2
   } cmd_type;

   // register index as decoded from the word address
   typedef enum logic {
      REG_RETRY_LIMIT = 1'b0
   } reg_type;

   // command broadcast to every cell during a scan
   typedef struct packed {
      cmd_type            cmd;
      logic [MAC_W-1:0]   dest_mac;
      logic [MAC_W-1:0]   src_mac;
      logic [ACK_W-1:0]   ack_code;
      logic [MSG_W-1:0]   msg_id;
      logic [RETRY_W-1:0] limit;
   } op_type;

   // scan packet handed from cell to cell
   typedef struct packed {
      logic               live;
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [MAC_W-1:0]   dest_mac;
      logic [MAC_W-1:0]   src_mac;
      logic [ACK_W-1:0]   ack_code;
      logic [MSG_W-1:0]   msg_id;
      logic [RETRY_W-1:0] retries;
   } pkt_type;

endpackage

// ===== hw/rtl/prtt_if.sv =====
// ----------------------------------------------------------------------------
// prtt_if
// request and response channels of the pending ack retry table
// ----------------------------------------------------------------------------
interface prtt_req_if;
   logic                           valid;
   logic                           ready;
   logic [prtt_pkg::CMD_W-1:0]     command;
   logic [prtt_pkg::MAC_W-1:0]     dest_mac;
   logic [prtt_pkg::MAC_W-1:0]     src_mac;
   logic [prtt_pkg::ACK_W-1:0]     ack_code;
   logic [prtt_pkg::MSG_W-1:0]     msg_id;

   modport source (
      output valid, command, dest_mac, src_mac, ack_code, msg_id,
      input  ready
   );
   modport sink (
      input  valid, command, dest_mac, src_mac, ack_code, msg_id,
      output ready
   );
endinterface

interface prtt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           ok;
   logic [prtt_pkg::SLOT_W-1:0]    slot;
   logic [prtt_pkg::MAC_W-1:0]     out_dest_mac;
   logic [prtt_pkg::MAC_W-1:0]     out_src_mac;
   logic [prtt_pkg::ACK_W-1:0]     out_ack_code;
   logic [prtt_pkg::MSG_W-1:0]     out_msg_id;
   logic [prtt_pkg::RETRY_W-1:0]   retries_before;

   modport source (
      output valid, ok, slot, out_dest_mac, out_src_mac, out_ack_code, out_msg_id,
             retries_before,
      input  ready
   );
   modport sink (
      input  valid, ok, slot, out_dest_mac, out_src_mac, out_ack_code, out_msg_id,
             retries_before,
      output ready
   );
endinterface

// ===== hw/rtl/prtt_csr.sv =====
// ----------------------------------------------------------------------------
// prtt_csr
// apb register block holding the retry limit
// ----------------------------------------------------------------------------
module prtt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [prtt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [prtt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [prtt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [prtt_pkg::RETRY_W-1:0]       retry_limit
);

   logic [prtt_pkg::RETRY_W-1:0] limit_ff;
   logic [prtt_pkg::RETRY_W-1:0] limit_in;
   prtt_pkg::reg_type            reg_sel;
   logic                         hit_reg;

   always_comb begin
      reg_sel = prtt_pkg::reg_type'(csr_paddr[prtt_pkg::CSR_ADDR_W-1]);
      hit_reg = (reg_sel == prtt_pkg::REG_RETRY_LIMIT);
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_reg) begin
         limit_in = csr_pwdata[prtt_pkg::RETRY_W-1:0];
      end
      csr_prdata = '0;
      if (hit_reg) begin
         csr_prdata = prtt_pkg::CSR_DATA_W'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= prtt_pkg::RETRY_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign retry_limit = limit_ff;

endmodule

// ===== hw/rtl/prtt_cell.sv =====
// ----------------------------------------------------------------------------
// prtt_cell
// one table slot; claims the passing scan packet when the command matches
// ----------------------------------------------------------------------------
module prtt_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  prtt_pkg::op_type  op,
   input  prtt_pkg::pkt_type pkt_in,
   output prtt_pkg::pkt_type pkt_out
);

   logic [prtt_pkg::MAC_W-1:0]   dest_ff, dest_in;
   logic [prtt_pkg::MAC_W-1:0]   src_ff, src_in;
   logic [prtt_pkg::ACK_W-1:0]   ack_ff, ack_in;
   logic [prtt_pkg::MSG_W-1:0]   msg_ff, msg_in;
   logic [prtt_pkg::RETRY_W-1:0] retries_ff, retries_in;
   prtt_pkg::pkt_type            pkt_ff, pkt_in_w;
   logic                         occupied;
   logic                         match;
   logic                         take;

   always_comb begin
      occupied = (msg_ff != '0);
      case (op.cmd)
         prtt_pkg::CMD_STORE: begin
            match = (op.msg_id != '0) && !occupied;
         end
         prtt_pkg::CMD_REMOVE: begin
            match = occupied && (msg_ff == op.msg_id) && (dest_ff == op.src_mac);
         end
         prtt_pkg::CMD_CHECK: begin
            match = occupied;
         end
         default: begin
            match = 1'b0;
         end
      endcase
      take = pkt_in.live && !pkt_in.hit && match;

      dest_in    = dest_ff;
      src_in     = src_ff;
      ack_in     = ack_ff;
      msg_in     = msg_ff;
      retries_in = retries_ff;
      pkt_in_w   = pkt_in;

      if (take) begin
         pkt_in_w.hit  = 1'b1;
         pkt_in_w.slot = prtt_pkg::SLOT_W'(IDX);
         case (op.cmd)
            prtt_pkg::CMD_STORE: begin
               dest_in    = op.dest_mac;
               src_in     = op.src_mac;
               ack_in     = op.ack_code;
               msg_in     = op.msg_id;
               retries_in = op.limit;
            end
            prtt_pkg::CMD_CHECK: begin
               pkt_in_w.dest_mac = dest_ff;
               pkt_in_w.src_mac  = src_ff;
               pkt_in_w.ack_code = ack_ff;
               pkt_in_w.msg_id   = msg_ff;
               pkt_in_w.retries  = retries_ff;
               if (retries_ff <= prtt_pkg::RETRY_W'(1)) begin
                  dest_in    = '0;
                  src_in     = '0;
                  ack_in     = '0;
                  msg_in     = '0;
                  retries_in = '0;
               end else begin
                  retries_in = retries_ff - prtt_pkg::RETRY_W'(1);
               end
            end
            default: begin
               // remove on ack frees the slot
               dest_in    = '0;
               src_in     = '0;
               ack_in     = '0;
               msg_in     = '0;
               retries_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_ff      <= '0;
         pkt_ff.live <= 1'b0;
      end else begin
         msg_ff <= msg_in;
         pkt_ff <= pkt_in_w;
      end
      dest_ff    <= dest_in;
      src_ff     <= src_in;
      ack_ff     <= ack_in;
      retries_ff <= retries_in;
   end

   assign pkt_out = pkt_ff;

endmodule

// ===== hw/rtl/pending_ack_retry_table_unit.sv =====
// ----------------------------------------------------------------------------
// pending_ack_retry_table_unit
// table of sent messages awaiting an ack, scanned by a chain of slot cells
// ----------------------------------------------------------------------------
// flow: an accepted request registers start_ff and op_ff; the scan packet
//   walks the cell chain one slot per cycle and the last cell's packet is
//   registered as the response; a new request waits for the scan to end
// reset: synchronous; all slots free, retry limit 5, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pending_ack_retry_table_unit #(
   parameter int unsigned SLOTS = prtt_pkg::NUM_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   prtt_req_if.sink                         req_ch,
   prtt_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [prtt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [prtt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [prtt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic [prtt_pkg::RETRY_W-1:0] retry_limit;
   prtt_pkg::op_type             op_ff, op_in;
   logic                         busy_ff, busy_in;
   logic                         start_ff, start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   prtt_pkg::pkt_type            rsp_ff, rsp_in;
   prtt_pkg::pkt_type            head_pkt;
   prtt_pkg::pkt_type            pkt_w [SLOTS];
   prtt_pkg::pkt_type            last_pkt;
   logic [SLOTS:0]               live_vec;
   logic                         accept;

   prtt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .retry_limit (retry_limit)
   );

   always_comb begin
      head_pkt      = '0;
      head_pkt.live = start_ff;
   end

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      if (k == 0) begin : g_first
         prtt_cell #(.IDX(k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .op      (op_ff),
            .pkt_in  (head_pkt),
            .pkt_out (pkt_w[k])
         );
      end else begin : g_next
         prtt_cell #(.IDX(k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .op      (op_ff),
            .pkt_in  (pkt_w[k-1]),
            .pkt_out (pkt_w[k])
         );
      end
      assign live_vec[k+1] = pkt_w[k].live;
   end

   assign live_vec[0] = start_ff;
   assign last_pkt    = pkt_w[SLOTS-1];

   assign req_ch.ready = !busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      op_in        = op_ff;
      busy_in      = busy_ff;
      start_in     = accept;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         op_in.cmd      = prtt_pkg::cmd_type'(req_ch.command);
         op_in.dest_mac = req_ch.dest_mac;
         op_in.src_mac  = req_ch.src_mac;
         op_in.ack_code = req_ch.ack_code;
         op_in.msg_id   = req_ch.msg_id;
         op_in.limit    = retry_limit;
         busy_in        = 1'b1;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (last_pkt.live) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = last_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.ok             = rsp_ff.hit;
   assign rsp_ch.slot           = rsp_ff.slot;
   assign rsp_ch.out_dest_mac   = rsp_ff.dest_mac;
   assign rsp_ch.out_src_mac    = rsp_ff.src_mac;
   assign rsp_ch.out_ack_code   = rsp_ff.ack_code;
   assign rsp_ch.out_msg_id     = rsp_ff.msg_id;
   assign rsp_ch.retries_before = rsp_ff.retries;

   // one scan at a time in the chain
   `ASSERT_CLK(a_single_scan, $countones(live_vec) <= 1)
   // scan result never lands on an undelivered response
   `ASSERT_NEVER(a_rsp_overrun, last_pkt.live && rsp_valid_ff && !rsp_ch.ready)
   // a miss reports slot zero
   `ASSERT_CLK(a_miss_slot, (rsp_valid_ff && !rsp_ff.hit) |-> (rsp_ff.slot == '0))
   // a scan started is finished while busy
   `ASSERT_CLK(a_busy_scan, (live_vec != '0) |-> busy_ff)

endmodule
